@@ design/ufs_pkg.sv @@
package ufs_pkg;

  // Default sizes handed to the top level parameters.
  localparam int QUEUE_COUNT_DEF   = 64;
  localparam int POSITION_BITS_DEF = 16;

  // Configuration register indexes.
  localparam int CFG_INDEX_BITS = 8;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_PORT_RANGE_LOW  = 8'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_PORT_RANGE_HIGH = 8'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_PORT_SINGLE     = 8'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_QUEUE_BOUND     = 8'd3;

  localparam int CFG_DATA_BITS = 64;

  // Register reset values.
  localparam logic [15:0] PORT_RANGE_LOW_RST  = 16'd12000;
  localparam logic [15:0] PORT_RANGE_HIGH_RST = 16'd12100;
  localparam logic [15:0] PORT_SINGLE_RST     = 16'd8001;
  localparam logic [63:0] QUEUE_BOUND_RST     = 64'd0;

  // Protocol constants.
  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  IP_PROTO_UDP   = 8'd17;
  localparam logic [3:0]  IHL_MIN        = 4'd5;
  localparam logic [13:0] FRAG_MASK      = 14'h3FFF;

  // Byte offsets inside the frame.
  localparam int OFS_ETHERTYPE_HI = 12;
  localparam int OFS_ETHERTYPE_LO = 13;
  localparam int OFS_IHL          = 14;
  localparam int OFS_FRAG_HI      = 20;
  localparam int OFS_FRAG_LO      = 21;
  localparam int OFS_PROTOCOL     = 23;
  localparam int OFS_PORT_SEARCH  = 15;
  localparam int OFS_DPORT_BASE   = 16;  // Ethernet header plus UDP source port
  localparam int LEN_ETH          = 14;
  localparam int LEN_ETH_IP       = 34;
  localparam int LEN_UDP_BASE     = 22;  // Ethernet header plus UDP header

  typedef enum logic [2:0] {
    RSN_REDIRECT  = 3'd0,
    RSN_SHORT     = 3'd1,
    RSN_NOT_IPV4  = 3'd2,
    RSN_BAD_PROTO = 3'd3,
    RSN_FRAGMENT  = 3'd4,
    RSN_NO_PORT   = 3'd5,
    RSN_UNBOUND   = 3'd6
  } reason_t;

  typedef struct packed {
    logic [15:0] port_range_low;
    logic [15:0] port_range_high;
    logic [15:0] port_single;
    logic [63:0] queue_bound_mask;
  } steer_cfg_t;

  typedef struct packed {
    logic [15:0] ether_type;
    logic [3:0]  header_words;
    logic [7:0]  ip_protocol;
    logic [13:0] fragment_bits;
    logic [15:0] dest_port;
    logic [5:0]  frame_queue;
  } hdr_fields_t;

  typedef struct packed {
    logic        verdict;
    logic [5:0]  target_queue;
    reason_t     reason;
  } verdict_t;

endpackage

@@ design/ufs_cfg_regs.sv @@
module ufs_cfg_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ufs_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [ufs_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  output ufs_pkg::steer_cfg_t              cfg
);
  import ufs_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.port_range_low   <= PORT_RANGE_LOW_RST;
      cfg.port_range_high  <= PORT_RANGE_HIGH_RST;
      cfg.port_single      <= PORT_SINGLE_RST;
      cfg.queue_bound_mask <= QUEUE_BOUND_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_PORT_RANGE_LOW:  cfg.port_range_low   <= cfg_data[15:0];
        CFG_PORT_RANGE_HIGH: cfg.port_range_high  <= cfg_data[15:0];
        CFG_PORT_SINGLE:     cfg.port_single      <= cfg_data[15:0];
        CFG_QUEUE_BOUND:     cfg.queue_bound_mask <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

@@ design/ufs_hdr_capture.sv @@
module ufs_hdr_capture #(
  parameter int POSITION_BITS = ufs_pkg::POSITION_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     step,
  input  logic [7:0]               data_byte,
  input  logic                     last_byte,
  input  logic [5:0]               rx_queue,
  output ufs_pkg::hdr_fields_t     hdr_next,
  output logic [POSITION_BITS:0]   frame_len
);
  import ufs_pkg::*;

  localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

  logic [POSITION_BITS-1:0] byte_position;
  logic [POSITION_BITS-1:0] byte_position_next;
  logic [POSITION_BITS-1:0] port_at;
  hdr_fields_t              hdr;
  logic                     pos_live;

  assign pos_live = (byte_position != POS_MAX);
  assign port_at  = POSITION_BITS'(OFS_DPORT_BASE) + POSITION_BITS'({hdr.header_words, 2'b00});
  assign frame_len = {1'b0, byte_position} + (POSITION_BITS+1)'(1);

  // Header fields as they stand once the current byte has been taken in;
  // the verdict for a last byte must see that byte's own capture.
  always_comb begin
    hdr_next = hdr;
    if (byte_position == '0) hdr_next.frame_queue = rx_queue;
    if (pos_live) begin
      if (byte_position == POSITION_BITS'(OFS_ETHERTYPE_HI)) hdr_next.ether_type[15:8] = data_byte;
      if (byte_position == POSITION_BITS'(OFS_ETHERTYPE_LO)) hdr_next.ether_type[7:0]  = data_byte;
      if (byte_position == POSITION_BITS'(OFS_IHL)) hdr_next.header_words = data_byte[3:0];
      if (byte_position == POSITION_BITS'(OFS_FRAG_HI)) hdr_next.fragment_bits[13:8] = data_byte[5:0];
      if (byte_position == POSITION_BITS'(OFS_FRAG_LO)) hdr_next.fragment_bits[7:0]  = data_byte;
      if (byte_position == POSITION_BITS'(OFS_PROTOCOL)) hdr_next.ip_protocol = data_byte;
      if (byte_position >= POSITION_BITS'(OFS_PORT_SEARCH)) begin
        if (byte_position == port_at) hdr_next.dest_port[15:8] = data_byte;
        if (byte_position == port_at + POSITION_BITS'(1)) hdr_next.dest_port[7:0] = data_byte;
      end
    end
  end

  always_comb begin
    byte_position_next = byte_position;
    if (pos_live) byte_position_next = byte_position + POSITION_BITS'(1);
    if (last_byte) byte_position_next = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      hdr           <= '0;
    end else if (step) begin
      byte_position <= byte_position_next;
      hdr           <= hdr_next;
    end
  end

endmodule

@@ design/ufs_verdict.sv @@
module ufs_verdict #(
  parameter int QUEUE_COUNT   = ufs_pkg::QUEUE_COUNT_DEF,
  parameter int POSITION_BITS = ufs_pkg::POSITION_BITS_DEF
) (
  input  ufs_pkg::steer_cfg_t    cfg,
  input  ufs_pkg::hdr_fields_t   hdr,
  input  logic [POSITION_BITS:0] frame_len,
  output ufs_pkg::verdict_t      result
);
  import ufs_pkg::*;

  localparam int LW = POSITION_BITS + 1;

  logic [LW-1:0] udp_need;
  logic          port_hit;
  logic          queue_ok;
  reason_t       reason;

  assign udp_need = LW'(LEN_UDP_BASE) + LW'({hdr.header_words, 2'b00});

  // An inverted range matches nothing, leaving only the single port.
  assign port_hit = ((hdr.dest_port >= cfg.port_range_low) &&
                     (hdr.dest_port <= cfg.port_range_high)) ||
                    (hdr.dest_port == cfg.port_single);

  // Queues at or past the configured count never have a socket.
  assign queue_ok = ({1'b0, hdr.frame_queue} < 7'(QUEUE_COUNT)) &&
                    cfg.queue_bound_mask[hdr.frame_queue];

  always_comb begin
    priority if (frame_len < LW'(LEN_ETH))                  reason = RSN_SHORT;
    else if (hdr.ether_type != ETHERTYPE_IPV4)              reason = RSN_NOT_IPV4;
    else if (frame_len < LW'(LEN_ETH_IP))                   reason = RSN_SHORT;
    else if ((hdr.header_words < IHL_MIN) ||
             (hdr.ip_protocol != IP_PROTO_UDP))             reason = RSN_BAD_PROTO;
    else if ((hdr.fragment_bits & FRAG_MASK) != '0)         reason = RSN_FRAGMENT;
    else if (frame_len < udp_need)                          reason = RSN_SHORT;
    else if (!port_hit)                                     reason = RSN_NO_PORT;
    else if (!queue_ok)                                     reason = RSN_UNBOUND;
    else                                                    reason = RSN_REDIRECT;
  end

  always_comb begin
    result.reason       = reason;
    result.verdict      = (reason == RSN_REDIRECT);
    result.target_queue = (reason == RSN_REDIRECT) ? hdr.frame_queue : 6'd0;
  end

endmodule

@@ design/udp_port_frame_steer_unit.sv @@
// Channel     | Dir | Signals                           | Transaction
// ------------+-----+-----------------------------------+-------------------------------
// frame in    | in  | s_tvalid s_tready s_tdata s_tuser | one frame byte, tlast on final
//             |     | s_tlast                           |
// verdict out | out | m_tvalid m_tready m_tdata          | one verdict per frame
// config      | in  | cfg_valid cfg_ready cfg_index     | one register write
//             |     | cfg_data                          |
//
// One byte is accepted per clock cycle when the verdict side is not stalled.
// A byte is held in an input register, then parsed against the captured header
// state; the verdict of a final byte is loaded into the output register when
// that byte leaves the input register, and is then offered on the verdict stream.
// Reset is synchronous and restores the register defaults and a fresh frame.
// A pending verdict that is not taken only stalls a following final byte;
// bytes inside a frame keep flowing.
module udp_port_frame_steer_unit #(
  parameter int QUEUE_COUNT   = ufs_pkg::QUEUE_COUNT_DEF,
  parameter int POSITION_BITS = ufs_pkg::POSITION_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  // Frame byte stream.
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [7:0]                         s_tdata,  // [7:0] data_byte
  input  logic [5:0]                         s_tuser,  // [5:0] rx_queue
  input  logic                               s_tlast,  // last_byte
  // Verdict stream.
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [15:0]                        m_tdata,  // [0] verdict, [6:1] target_queue,
                                                       // [9:7] reason, [15:10] zero
  // Register writes.
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ufs_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [ufs_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import ufs_pkg::*;

  steer_cfg_t               cfg;
  hdr_fields_t              hdr_next;
  verdict_t                 result;
  logic [POSITION_BITS:0]   frame_len;

  // Input register.
  logic       in_valid;
  logic [7:0] in_data;
  logic       in_last;
  logic [5:0] in_queue;
  logic       in_step;

  // Output register.
  logic       out_valid;
  verdict_t   out_result;

  // The held byte moves on unless it is a final byte and the output register
  // still holds a verdict that is not being taken this cycle.
  assign in_step  = in_valid && (!in_last || !out_valid || m_tready);
  assign s_tready = !in_valid || in_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready) begin
      in_data  <= s_tdata;
      in_last  <= s_tlast;
      in_queue <= s_tuser;
    end
  end

  ufs_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ufs_hdr_capture #(
    .POSITION_BITS (POSITION_BITS)
  ) u_capture (
    .clk       (clk),
    .rst       (rst),
    .step      (in_step),
    .data_byte (in_data),
    .last_byte (in_last),
    .rx_queue  (in_queue),
    .hdr_next  (hdr_next),
    .frame_len (frame_len)
  );

  ufs_verdict #(
    .QUEUE_COUNT   (QUEUE_COUNT),
    .POSITION_BITS (POSITION_BITS)
  ) u_verdict (
    .cfg       (cfg),
    .hdr       (hdr_next),
    .frame_len (frame_len),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_step && in_last) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_step && in_last) begin
      out_result <= result;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {6'd0, out_result.reason, out_result.target_queue, out_result.verdict};

endmodule

@@ sim/udp_port_frame_steer_unit_test.sv @@
module udp_port_frame_steer_unit_test;
  import ufs_pkg::*;

  // A short byte counter keeps the saturating frame down to 132 bytes;
  // every other frame stays well below the saturation point.
  localparam int          POS_BITS      = 7;
  localparam int unsigned POS_SAT       = (1 << POS_BITS) - 1;
  localparam int          LONG_FRAME    = (1 << POS_BITS) + 4;
  localparam int          SETTLE_CYCLES = 6;
  localparam int          STALL_LIMIT   = 2000;
  localparam int          PHASES        = 6;
  localparam int          PHASE_BYTES   = 40;
  localparam int          PHASE_FRAMES  = 1;

  typedef enum logic {ROW_FRAME, ROW_WRITE} row_kind_t;

  // Per-frame verdict that the directed table types in, or leaves to the predictor.
  typedef struct {
    bit       known;
    verdict_t v;
  } frame_note_t;

  typedef struct {
    row_kind_t                 kind;
    logic [CFG_INDEX_BITS-1:0] reg_index;
    logic [CFG_DATA_BITS-1:0]  reg_value;
    int                        len;      // 0 keeps the natural header length
    logic [15:0]               etype;
    logic [7:0]                vihl;
    logic [7:0]                proto;
    logic [15:0]               frag;
    logic [15:0]               dport;
    logic [5:0]                queue;
    frame_note_t               note;
  } steer_row_t;

  localparam frame_note_t OPEN_NOTE = '{known: 1'b0, v: '0};

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                      s_tvalid = 1'b0;
  logic                      s_tready;
  logic [7:0]                s_tdata  = '0;
  logic [5:0]                s_tuser  = '0;
  logic                      s_tlast  = 1'b0;
  logic                      m_tvalid;
  logic                      m_tready = 1'b1;
  logic [15:0]               m_tdata;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;

  udp_port_frame_steer_unit #(
    .POSITION_BITS (POS_BITS)
  ) u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Mirror of the steering registers, updated on every accepted write transaction.
  logic [15:0] port_lo   = PORT_RANGE_LOW_RST;
  logic [15:0] port_hi   = PORT_RANGE_HIGH_RST;
  logic [15:0] port_one  = PORT_SINGLE_RST;
  logic [63:0] bound_map = QUEUE_BOUND_RST;

  // Mirror of the parser state; all of it starts at zero.
  logic [POS_BITS-1:0] byte_pos      = '0;
  logic [15:0]         ether_type    = '0;
  logic [3:0]          header_words  = '0;
  logic [7:0]          ip_protocol   = '0;
  logic [13:0]         fragment_bits = '0;
  logic [15:0]         dest_port     = '0;
  logic [5:0]          frame_queue   = '0;

  verdict_t    verdicts_due[$];
  frame_note_t row_verdicts[$];
  logic [7:0]  frame_bytes[$];
  steer_row_t  directed[$];

  int  errors      = 0;
  int  bytes_sent  = 0;
  int  frames_sent = 0;
  int  settings    = 0;
  int  reason_hits[8];
  bit  calm        = 1'b0;
  int  stall_left  = 0;

  task automatic flag_mismatch(input string what, input longint got, input longint want);
    $display("mismatch at frame %0d: %s got %0h want %0h", frames_sent, what, got, want);
    errors++;
  endtask

  // Advance the parser mirror by one byte. On a final byte it also yields the verdict,
  // with the checks taken in the order the block applies them.
  function automatic void steer_step(input logic [7:0] b, input logic last,
                                     input logic [5:0] q, output bit emits,
                                     output verdict_t v);
    int unsigned pos;
    int unsigned len;
    int unsigned port_at;
    reason_t     why;
    pos   = byte_pos;
    emits = 1'b0;
    v     = '0;
    if (pos == 0) frame_queue = q;
    // A saturated counter freezes every capture for the rest of the frame.
    if (pos < POS_SAT) begin
      case (pos)
        OFS_ETHERTYPE_HI: ether_type[15:8]   = b;
        OFS_ETHERTYPE_LO: ether_type[7:0]    = b;
        OFS_IHL:          header_words       = b[3:0];
        OFS_FRAG_HI:      fragment_bits[13:8] = b[5:0];
        OFS_FRAG_LO:      fragment_bits[7:0] = b;
        OFS_PROTOCOL:     ip_protocol        = b;
        default: ;
      endcase
      if (pos >= OFS_PORT_SEARCH) begin
        port_at = OFS_DPORT_BASE + 4 * header_words;
        if (pos == port_at)     dest_port[15:8] = b;
        if (pos == port_at + 1) dest_port[7:0]  = b;
      end
      byte_pos = byte_pos + 1'b1;
    end
    if (last) begin
      len      = pos + 1;
      byte_pos = '0;
      if (len < LEN_ETH)                                            why = RSN_SHORT;
      else if (ether_type != ETHERTYPE_IPV4)                        why = RSN_NOT_IPV4;
      else if (len < LEN_ETH_IP)                                    why = RSN_SHORT;
      else if (header_words < IHL_MIN || ip_protocol != IP_PROTO_UDP) why = RSN_BAD_PROTO;
      else if ((fragment_bits & FRAG_MASK) != 0)                    why = RSN_FRAGMENT;
      else if (len < LEN_UDP_BASE + 4 * header_words)               why = RSN_SHORT;
      else if (!((dest_port >= port_lo && dest_port <= port_hi) || dest_port == port_one))
        why = RSN_NO_PORT;
      else if (frame_queue >= QUEUE_COUNT_DEF || !bound_map[frame_queue])
        why = RSN_UNBOUND;
      else
        why = RSN_REDIRECT;
      emits          = 1'b1;
      v.verdict      = (why == RSN_REDIRECT);
      v.target_queue = (why == RSN_REDIRECT) ? frame_queue : 6'd0;
      v.reason       = why;
    end
  endfunction

  // Everything is sampled at the rising edge, before the drivers' updates of that edge land.
  always @(posedge clk) begin : track
    bit          emits;
    verdict_t    predicted;
    verdict_t    want;
    frame_note_t note;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_PORT_RANGE_LOW:  port_lo   = cfg_data[15:0];
          CFG_PORT_RANGE_HIGH: port_hi   = cfg_data[15:0];
          CFG_PORT_SINGLE:     port_one  = cfg_data[15:0];
          CFG_QUEUE_BOUND:     bound_map = cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        steer_step(s_tdata, s_tlast, s_tuser, emits, predicted);
        if (emits) begin
          note = (row_verdicts.size() != 0) ? row_verdicts.pop_front() : OPEN_NOTE;
          want = note.known ? note.v : predicted;
          verdicts_due.push_back(want);
          reason_hits[want.reason]++;
        end
      end
      if (m_tvalid && m_tready) begin
        if (verdicts_due.size() == 0) begin
          flag_mismatch("verdict with nothing pending", m_tdata, 0);
        end else begin
          want = verdicts_due.pop_front();
          if (m_tdata[0] !== want.verdict)        flag_mismatch("verdict", m_tdata[0], want.verdict);
          if (m_tdata[6:1] !== want.target_queue)
            flag_mismatch("target_queue", m_tdata[6:1], want.target_queue);
          if (m_tdata[9:7] !== want.reason)       flag_mismatch("reason", m_tdata[9:7], want.reason);
          if (m_tdata[15:10] !== '0)              flag_mismatch("pad bits", m_tdata[15:10], 0);
        end
      end
    end
  end

  // The verdict side stalls in short random bursts unless a calm stretch is running.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      m_tready   <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      m_tready   <= 1'b0;
      stall_left <= $urandom_range(0, 2);
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Any accepted transaction on any channel, or reset, resets the count.
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("no transaction for %0d cycles, %0d verdicts outstanding", STALL_LIMIT,
             verdicts_due.size());
    $display("[FAIL] regression broken");
    $finish;
  end

  // Valid stays up between back-to-back bytes; it only drops for an idle burst.
  task automatic send_byte(input logic [7:0] b, input logic last, input logic [5:0] q);
    int gap;
    if (!calm && $urandom_range(0, 9) == 0) begin
      gap = $urandom_range(1, 3);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    s_tuser  <= q;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    bytes_sent++;
  endtask

  // Later bytes may carry a different queue number; only the first one counts.
  task automatic send_frame(input frame_note_t note, input logic [5:0] q, input bit mix);
    int n;
    row_verdicts.push_back(note);
    n = frame_bytes.size();
    for (int i = 0; i < n; i++)
      send_byte(frame_bytes[i], i == n - 1, (i == 0 || !mix) ? q : 6'($urandom));
    frames_sent++;
  endtask

  // Stop sending and wait until every verdict has come back and the pipeline is empty.
  task automatic hold_off();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (verdicts_due.size() != 0 || row_verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_setting(input logic [15:0] lo, input logic [15:0] hi,
                              input logic [15:0] one, input logic [63:0] map);
    write_reg(CFG_PORT_RANGE_LOW, 64'(lo));
    write_reg(CFG_PORT_RANGE_HIGH, 64'(hi));
    write_reg(CFG_PORT_SINGLE, 64'(one));
    write_reg(CFG_QUEUE_BOUND, map);
    settings++;
  endtask

  // Ethernet + IPv4 (with IHL options) + UDP header with random filler, then payload.
  function automatic void build_frame(input logic [15:0] etype, input logic [7:0] vihl,
                                      input logic [7:0] proto, input logic [15:0] frag,
                                      input logic [15:0] dport, input int payload);
    int opts;
    opts = (vihl[3:0] > IHL_MIN) ? 4 * (vihl[3:0] - IHL_MIN) : 0;
    frame_bytes.delete();
    repeat (12) frame_bytes.push_back(8'($urandom));
    frame_bytes.push_back(etype[15:8]);
    frame_bytes.push_back(etype[7:0]);
    frame_bytes.push_back(vihl);
    repeat (5) frame_bytes.push_back(8'($urandom));
    frame_bytes.push_back(frag[15:8]);
    frame_bytes.push_back(frag[7:0]);
    frame_bytes.push_back(8'($urandom));
    frame_bytes.push_back(proto);
    repeat (10 + opts + 2) frame_bytes.push_back(8'($urandom));
    frame_bytes.push_back(dport[15:8]);
    frame_bytes.push_back(dport[7:0]);
    repeat (4 + payload) frame_bytes.push_back(8'($urandom));
  endfunction

  function automatic void fit_frame(input int len);
    while (frame_bytes.size() > len) void'(frame_bytes.pop_back());
    while (frame_bytes.size() < len) frame_bytes.push_back(8'($urandom));
  endfunction

  // Ports on and just outside the matching edges, some inside the range, and some fully random ones.
  function automatic logic [15:0] pick_port();
    case ($urandom_range(0, 7))
      0: return port_lo;
      1: return port_hi;
      2: return port_lo - 16'd1;
      3: return port_hi + 16'd1;
      4: return port_one;
      5: return port_one + 16'd1;
      6: return port_lo + 16'($urandom_range(0, 32'(port_hi - port_lo)));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic steer_row_t frame_row(input int len, input logic [15:0] etype,
                                           input logic [7:0] vihl, input logic [7:0] proto,
                                           input logic [15:0] frag, input logic [15:0] dport,
                                           input logic [5:0] q, input bit known,
                                           input reason_t why);
    steer_row_t r;
    r                     = '{kind: ROW_FRAME, default: '0};
    r.len                 = len;
    r.etype               = etype;
    r.vihl                = vihl;
    r.proto               = proto;
    r.frag                = frag;
    r.dport               = dport;
    r.queue               = q;
    r.note.known          = known;
    r.note.v.verdict      = (why == RSN_REDIRECT);
    r.note.v.target_queue = (why == RSN_REDIRECT) ? q : 6'd0;
    r.note.v.reason       = why;
    return r;
  endfunction

  function automatic steer_row_t reg_row(input logic [CFG_INDEX_BITS-1:0] idx,
                                         input logic [CFG_DATA_BITS-1:0] value);
    steer_row_t r;
    r           = '{kind: ROW_WRITE, default: '0};
    r.reg_index = idx;
    r.reg_value = value;
    return r;
  endfunction

  initial begin : stimulus
    steer_row_t  r;
    logic [15:0] lo;
    logic [15:0] hi;
    logic [3:0]  ihl;
    logic [15:0] frag;
    int          ph_start;
    int          ph_frames;

    // Directed frames. Rows that carry a typed verdict are checked against it; the
    // rest go to the predictor. Registers hold their reset values until the first write.
    directed.push_back(frame_row(1,  16'h0800, 8'h45, 8'd17, 16'h0000, 16'd12000, 6'd1,  1, RSN_SHORT));
    directed.push_back(frame_row(13, 16'h0800, 8'h45, 8'd17, 16'h0000, 16'd12000, 6'd2,  1, RSN_SHORT));
    directed.push_back(frame_row(14, 16'h0800, 8'h45, 8'd17, 16'h0000, 16'd12000, 6'd3,  1, RSN_SHORT));
    directed.push_back(frame_row(14, 16'h86DD, 8'h45, 8'd17, 16'h0000, 16'd12000, 6'd4,  1, RSN_NOT_IPV4));
    directed.push_back(frame_row(33, 16'h0800, 8'h45, 8'd17, 16'h0000, 16'd12000, 6'd5,  1, RSN_SHORT));
    directed.push_back(frame_row(0,  16'h0800, 8'h45, 8'd17, 16'h0000, 16'd12000, 6'd3,  1, RSN_UNBOUND));
    directed.push_back(frame_row(0,  16'h0800, 8'h44, 8'd17, 16'h0000, 16'd12000, 6'd6,  1, RSN_BAD_PROTO));
    directed.push_back(frame_row(0,  16'h0800, 8'h40, 8'd17, 16'h0000, 16'd12000, 6'd7,  1, RSN_BAD_PROTO));
    directed.push_back(frame_row(0,  16'h0800, 8'h45, 8'd6,  16'h0000, 16'd12000, 6'd8,  1, RSN_BAD_PROTO));
    directed.push_back(frame_row(0,  16'h0800, 8'h45, 8'd17, 16'h2000, 16'd12000, 6'd9,  1, RSN_FRAGMENT));
    directed.push_back(frame_row(0,  16'h0800, 8'h45, 8'd17, 16'h0001, 16'd12000, 6'd10, 1, RSN_FRAGMENT));
    // Don't-fragment and the reserved flag sit outside the fragment mask.
    directed.push_back(frame_row(0,  16'h0800, 8'h45, 8'd17, 16'hC000, 16'd11999, 6'd11, 1, RSN_NO_PORT));
    directed.push_back(frame_row(0,  16'h0800, 8'h45, 8'd17, 16'h0000, 16'd12101, 6'd12, 1, RSN_NO_PORT));
    directed.push_back(frame_row(81, 16'h0800, 8'h4F, 8'd17, 16'h0000, 16'd12000, 6'd13, 1, RSN_SHORT));
    directed.push_back(frame_row(0,  16'h0800, 8'h4F, 8'd17, 16'h0000, 16'd8001,  6'd14, 1, RSN_UNBOUND));
    directed.push_back(frame_row(35, 16'h0800, 8'h43, 8'd17, 16'h0000, 16'd12000, 6'd15, 0, RSN_SHORT));
    directed.push_back(reg_row(CFG_QUEUE_BOUND, '1));
    directed.push_back(frame_row(0,  16'h0800, 8'h45, 8'd17, 16'h0000, 16'd12100, 6'd63, 1, RSN_REDIRECT));
    // The version nibble is never checked.
    directed.push_back(frame_row(0,  16'h0800, 8'hF6, 8'd17, 16'h0000, 16'd12000, 6'd0,  1, RSN_REDIRECT));
    // Longer than the byte counter can count: it saturates and still counts as long enough.
    directed.push_back(frame_row(LONG_FRAME, 16'h0800, 8'h45, 8'd17, 16'h0000, 16'd8001, 6'd42,
                                 1, RSN_REDIRECT));
    directed.push_back(reg_row(CFG_QUEUE_BOUND, 64'h8000_0000_0000_0001));
    directed.push_back(frame_row(0,  16'h0800, 8'h45, 8'd17, 16'h0000, 16'd12050, 6'd62, 1, RSN_UNBOUND));
    directed.push_back(frame_row(0,  16'h0800, 8'h45, 8'd17, 16'h0000, 16'd12050, 6'd0,  1, RSN_REDIRECT));
    // An inverted range matches nothing; only the single port remains.
    directed.push_back(reg_row(CFG_PORT_RANGE_LOW, 64'hFFFF));
    directed.push_back(reg_row(CFG_PORT_RANGE_HIGH, 64'h0000));
    directed.push_back(reg_row(CFG_PORT_SINGLE, 64'h0000));
    directed.push_back(frame_row(0,  16'h0800, 8'h45, 8'd17, 16'h0000, 16'd0,     6'd63, 1, RSN_REDIRECT));
    directed.push_back(frame_row(0,  16'h0800, 8'h45, 8'd17, 16'h0000, 16'hFFFF,  6'd63, 1, RSN_NO_PORT));
    directed.push_back(frame_row(0,  16'h0800, 8'h46, 8'd17, 16'h4000, 16'd12000, 6'd0,  0, RSN_SHORT));

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) begin
      r = directed[i];
      if (r.kind == ROW_WRITE) begin
        hold_off();
        write_reg(r.reg_index, r.reg_value);
        settings++;
      end else begin
        build_frame(r.etype, r.vihl, r.proto, r.frag, r.dport, 0);
        if (r.len != 0) fit_frame(r.len);
        send_frame(r.note, r.queue, 1'b1);
      end
    end

    // Random phases, each under its own register setting. The last one runs without
    // any idling on either side.
    for (int ph = 0; ph < PHASES; ph++) begin
      hold_off();
      case (ph)
        0: begin
          lo = 16'($urandom_range(0, 65000));
          load_setting(lo, lo + 16'($urandom_range(0, 500)), 16'($urandom),
                       {$urandom, $urandom});
        end
        1: load_setting(16'h0000, 16'hFFFF, 16'($urandom), '1);
        2: begin
          lo = 16'($urandom_range(1, 65535));
          hi = 16'($urandom_range(0, 32'(lo) - 1));
          load_setting(lo, hi, 16'hFFFF, {$urandom, $urandom});
        end
        3: begin
          lo = 16'($urandom);
          load_setting(lo, lo, 16'h0000, '0);
        end
        4: load_setting(16'($urandom), 16'($urandom), 16'($urandom), {$urandom, $urandom});
        default: load_setting(PORT_RANGE_LOW_RST, PORT_RANGE_HIGH_RST, PORT_SINGLE_RST,
                              {$urandom, $urandom});
      endcase
      ph_start  = bytes_sent;
      ph_frames = 0;
      while (bytes_sent - ph_start < PHASE_BYTES || ph_frames < PHASE_FRAMES) begin
        calm = (ph == PHASES - 1) || ($urandom_range(0, 4) == 0);
        if (ph == 2 && ph_frames == 1) hold_off();
        if ($urandom_range(0, 4) == 0) begin
          // Noise: random bytes, sometimes with an IPv4 ethertype in place.
          frame_bytes.delete();
          fit_frame($urandom_range(1, 48));
          if (frame_bytes.size() > 13 && $urandom_range(0, 1) == 1) begin
            frame_bytes[OFS_ETHERTYPE_HI] = ETHERTYPE_IPV4[15:8];
            frame_bytes[OFS_ETHERTYPE_LO] = ETHERTYPE_IPV4[7:0];
          end
        end else begin
          case ($urandom_range(0, 9))
            0:       ihl = 4'($urandom_range(0, 4));
            1:       ihl = 4'($urandom_range(6, 15));
            default: ihl = IHL_MIN;
          endcase
          frag = ($urandom_range(0, 3) == 0) ? 16'($urandom) : {2'($urandom), 14'd0};
          build_frame(($urandom_range(0, 15) == 0) ? 16'($urandom) : ETHERTYPE_IPV4,
                      {4'($urandom), ihl},
                      ($urandom_range(0, 9) == 0) ? 8'($urandom) : IP_PROTO_UDP,
                      frag, pick_port(), $urandom_range(0, 4));
          if ($urandom_range(0, 7) == 0) fit_frame($urandom_range(1, frame_bytes.size()));
        end
        send_frame(OPEN_NOTE, 6'($urandom), $urandom_range(0, 3) == 0);
        ph_frames++;
      end
    end

    hold_off();
    $display("covered %0d frames, %0d bytes, %0d register settings", frames_sent, bytes_sent,
             settings);
    $display("verdicts: redirect %0d, short %0d, not ipv4 %0d, ihl/proto %0d, ",
             reason_hits[RSN_REDIRECT], reason_hits[RSN_SHORT], reason_hits[RSN_NOT_IPV4],
             reason_hits[RSN_BAD_PROTO],
             "fragment %0d, port %0d, unbound %0d",
             reason_hits[RSN_FRAGMENT], reason_hits[RSN_NO_PORT], reason_hits[RSN_UNBOUND]);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ udp_port_frame_steer_unit.f @@
design/ufs_pkg.sv
design/ufs_cfg_regs.sv
design/ufs_hdr_capture.sv
design/ufs_verdict.sv
design/udp_port_frame_steer_unit.sv
sim/udp_port_frame_steer_unit_test.sv
